// ===== design/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg: shared definitions for the pixel store blend engine
// Command codes, register indexes, field widths and the channel mixing
// arithmetic used by the blend-over command.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

   // Field and register widths
   localparam int CSR_WIDTH       = 17;
   localparam int XOFF_WIDTH      = 12;
   localparam int YOFF_WIDTH      = 12;
   localparam int PITCH_WIDTH     = 13;
   localparam int COUNT_REG_WIDTH = 17;
   localparam int POS_WIDTH       = 16;
   localparam int COLOR_WIDTH     = 32;
   localparam int MIX_WIDTH       = 16;

   // Register reset values
   localparam logic [PITCH_WIDTH-1:0]     ROW_PITCH_RESET   = 13'd256;
   localparam logic [COUNT_REG_WIDTH-1:0] PIXEL_COUNT_RESET = 17'd65536;

   // Full coverage alpha, also the channel divisor
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [1:0] {
      CMD_SET   = 2'd0,
      CMD_BLEND = 2'd1,
      CMD_GET   = 2'd2,
      CMD_FILL  = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      REG_X_OFFSET    = 2'd0,
      REG_Y_OFFSET    = 2'd1,
      REG_ROW_PITCH   = 2'd2,
      REG_PIXEL_COUNT = 2'd3
   } reg_index_type;

   // Step enables for the address unit
   typedef struct packed {
      logic mul_en;
      logic addr_en;
   } idx_ctrl_type;

   // fg*a + bg*(255-a); at most 255*255, so it fits 16 bits
   function automatic logic [MIX_WIDTH-1:0] mix_sum(input logic [7:0] fg,
                                                     input logic [7:0] bg,
                                                     input logic [7:0] a);
      logic [MIX_WIDTH-1:0] p_fg;
      logic [MIX_WIDTH-1:0] p_bg;
      logic [7:0]           inv_a;
      inv_a = ALPHA_OPAQUE - a;
      p_fg  = {8'b0, fg} * {8'b0, a};
      p_bg  = {8'b0, bg} * {8'b0, inv_a};
      return p_fg + p_bg;
   endfunction

   // Truncating divide by 255, exact for sums up to 255*255
   function automatic logic [7:0] div255(input logic [MIX_WIDTH-1:0] v);
      logic [MIX_WIDTH:0] t;
      t = {1'b0, v} + {9'b0, v[15:8]} + 17'd1;
      return t[15:8];
   endfunction

endpackage

`default_nettype wire

// ===== design/pse_index_unit.sv =====
// ----------------------------------------------------------------------------
// pse_index_unit: pixel address computation
// Forms (x + x_offset) + (y + y_offset) * row_pitch over two steps and
// clamps the result into the pixels in use, flagging any clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_index_unit #(
   parameter int PIXELS = 65536
) (
   input  wire                                          clock,
   input  wire pse_pkg::idx_ctrl_type                   ctrl,
   input  wire logic signed [pse_pkg::POS_WIDTH-1:0]    pos_x,
   input  wire logic signed [pse_pkg::POS_WIDTH-1:0]    pos_y,
   input  wire logic [pse_pkg::XOFF_WIDTH-1:0]          x_offset,
   input  wire logic [pse_pkg::YOFF_WIDTH-1:0]          y_offset,
   input  wire logic [pse_pkg::PITCH_WIDTH-1:0]         row_pitch,
   input  wire logic [$clog2(PIXELS+1)-1:0]             count,
   output logic [$clog2(PIXELS)-1:0]                    addr,
   output logic                                         clamped
);
   import pse_pkg::*;

   localparam int AW = $clog2(PIXELS);
   localparam int CW = $clog2(PIXELS + 1);
   localparam int SW = POS_WIDTH + 2;
   localparam int PW = 32;
   localparam int IW = PW + 1;

   logic signed [SW-1:0]            xsum;
   logic signed [SW-1:0]            ysum;
   logic signed [PITCH_WIDTH:0]     pitch_s;
   logic signed [PW-1:0]            prod;
   logic signed [SW-1:0]            xsum_ff;
   logic signed [PW-1:0]            prod_ff;
   logic signed [IW-1:0]            idx;
   logic signed [IW-1:0]            count_ext;
   logic [CW-1:0]                   last;
   logic [AW-1:0]                   addr_ff;
   logic                            clamped_ff;

   // Offset sums and row term
   assign xsum    = $signed({{2{pos_x[POS_WIDTH-1]}}, pos_x})
                  + $signed({{(SW-XOFF_WIDTH){1'b0}}, x_offset});
   assign ysum    = $signed({{2{pos_y[POS_WIDTH-1]}}, pos_y})
                  + $signed({{(SW-YOFF_WIDTH){1'b0}}, y_offset});
   assign pitch_s = $signed({1'b0, row_pitch});
   assign prod    = ysum * pitch_s;

   // Linear index and bounds
   assign idx       = IW'(prod_ff) + IW'(xsum_ff);
   assign count_ext = $signed({{(IW-CW){1'b0}}, count});
   assign last      = count - CW'(1);

   // Multiply step, then add and clamp step
   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         xsum_ff <= xsum;
         prod_ff <= prod;
      end
      if (ctrl.addr_en) begin
         if (idx[IW-1]) begin
            addr_ff    <= '0;
            clamped_ff <= 1'b1;
         end else if (idx >= count_ext) begin
            addr_ff    <= last[AW-1:0];
            clamped_ff <= 1'b1;
         end else begin
            addr_ff    <= idx[AW-1:0];
            clamped_ff <= 1'b0;
         end
      end
   end

   assign addr    = addr_ff;
   assign clamped = clamped_ff;

endmodule

`default_nettype wire

// ===== design/pixel_store_blend_engine.sv =====
// ----------------------------------------------------------------------------
// pixel_store_blend_engine: ARGB pixel memory with set, blend, get and fill
// Two-port pixel store with a read-modify-write sequencer around it.
// ----------------------------------------------------------------------------
// Usage:
//   A request (command, pos_x, pos_y, color) transfers at a rising edge with
//   start high and busy low. busy then stays high until the response.
//   Exactly one response per request: rsp_valid is high for one cycle with
//   rsp_read_color and rsp_index_clamped. The receiver cannot stall it.
//   The sequencer steps through address arithmetic (multiply, then add and
//   clamp), a registered memory read, channel multiplies, and divide and
//   write-back. Set writes and answers after the address steps, get answers
//   with the read data, blend over after the write-back; a new request
//   transfers only once the last one has its response. Fill writes one
//   pixel per cycle through the single write port. Registers are to be
//   written through csr_we/csr_index/csr_data only while idle; the block
//   itself does not enforce this. Reset (synchronous, active high) returns
//   the registers to their reset values and the sequencer to idle; pixel
//   contents are undefined until written, and no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_store_blend_engine #(
   parameter int PIXELS = 65536
) (
   input  wire                                          clock,
   input  wire                                          reset,
   // request channel
   input  wire                                          start,
   output logic                                         busy,
   input  wire logic [1:0]                              req_command,
   input  wire logic signed [pse_pkg::POS_WIDTH-1:0]    req_pos_x,
   input  wire logic signed [pse_pkg::POS_WIDTH-1:0]    req_pos_y,
   input  wire logic [pse_pkg::COLOR_WIDTH-1:0]         req_color,
   // response channel
   output logic                                         rsp_valid,
   output logic [pse_pkg::COLOR_WIDTH-1:0]              rsp_read_color,
   output logic                                         rsp_index_clamped,
   // register write port
   input  wire                                          csr_we,
   input  wire logic [1:0]                              csr_index,
   input  wire logic [pse_pkg::CSR_WIDTH-1:0]           csr_data
);
   import pse_pkg::*;

   localparam int AW = $clog2(PIXELS);
   localparam int CW = $clog2(PIXELS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_ADDR,
      S_READ,
      S_MIX,
      S_WRITE,
      S_FILL
   } state_type;

   state_type                    state_ff;
   logic                         busy_ff;
   logic                         rsp_valid_ff;
   logic [COLOR_WIDTH-1:0]       rsp_color_ff;
   logic                         rsp_clamped_ff;

   command_type                  cmd_ff;
   logic signed [POS_WIDTH-1:0]  pos_x_ff;
   logic signed [POS_WIDTH-1:0]  pos_y_ff;
   logic [COLOR_WIDTH-1:0]       color_ff;
   logic [AW-1:0]                fill_ff;
   logic [MIX_WIDTH-1:0]         mix_ff [3];

   logic [XOFF_WIDTH-1:0]        x_offset_ff;
   logic [YOFF_WIDTH-1:0]        y_offset_ff;
   logic [PITCH_WIDTH-1:0]       row_pitch_ff;
   logic [COUNT_REG_WIDTH-1:0]   pixel_count_ff;

   logic [31:0]                  count_wide;
   logic [CW-1:0]                count;
   logic [CW-1:0]                count_m1;
   logic [AW-1:0]                fill_last;

   idx_ctrl_type                 idx_ctrl;
   logic [AW-1:0]                idx_addr;
   logic                         idx_clamped;

   logic [COLOR_WIDTH-1:0]       pixel_mem [PIXELS];
   logic [COLOR_WIDTH-1:0]       rd_data_ff;
   logic                         mem_we;
   logic [AW-1:0]                mem_waddr;
   logic [COLOR_WIDTH-1:0]       mem_wdata;
   logic [COLOR_WIDTH-1:0]       blend_word;

   // Register writes; unknown indexes cannot occur on a two-bit index
   always_ff @(posedge clock) begin
      if (reset) begin
         x_offset_ff    <= '0;
         y_offset_ff    <= '0;
         row_pitch_ff   <= ROW_PITCH_RESET;
         pixel_count_ff <= PIXEL_COUNT_RESET;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_X_OFFSET:    x_offset_ff    <= csr_data[XOFF_WIDTH-1:0];
            REG_Y_OFFSET:    y_offset_ff    <= csr_data[YOFF_WIDTH-1:0];
            REG_ROW_PITCH:   row_pitch_ff   <= csr_data[PITCH_WIDTH-1:0];
            REG_PIXEL_COUNT: pixel_count_ff <= csr_data[COUNT_REG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Saturate pixel count into 1 .. PIXELS
   assign count_wide = {{(32-COUNT_REG_WIDTH){1'b0}}, pixel_count_ff};
   always_comb begin
      if (pixel_count_ff == '0) begin
         count = CW'(1);
      end else if (count_wide > 32'(PIXELS)) begin
         count = CW'(PIXELS);
      end else begin
         count = count_wide[CW-1:0];
      end
   end
   assign count_m1  = count - CW'(1);
   assign fill_last = count_m1[AW-1:0];

   // Address arithmetic
   assign idx_ctrl.mul_en  = (state_ff == S_MUL);
   assign idx_ctrl.addr_en = (state_ff == S_ADDR);

   pse_index_unit #(
      .PIXELS (PIXELS)
   ) u_index (
      .clock     (clock),
      .ctrl      (idx_ctrl),
      .pos_x     (pos_x_ff),
      .pos_y     (pos_y_ff),
      .x_offset  (x_offset_ff),
      .y_offset  (y_offset_ff),
      .row_pitch (row_pitch_ff),
      .count     (count),
      .addr      (idx_addr),
      .clamped   (idx_clamped)
   );

   // Blended pixel, always fully opaque
   assign blend_word = {ALPHA_OPAQUE, div255(mix_ff[2]), div255(mix_ff[1]),
                        div255(mix_ff[0])};

   // Write port select: sweep for fill, computed address otherwise
   assign mem_we    = (state_ff == S_FILL) || (state_ff == S_WRITE)
                   || ((state_ff == S_READ) && (cmd_ff == CMD_SET));
   assign mem_waddr = (state_ff == S_FILL) ? fill_ff : idx_addr;
   assign mem_wdata = (state_ff == S_WRITE) ? blend_word : color_ff;

   // Pixel memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pixel_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= pixel_mem[idx_addr];
   end

   // Sequencer: hold state, busy and the response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  cmd_ff   <= command_type'(req_command);
                  pos_x_ff <= req_pos_x;
                  pos_y_ff <= req_pos_y;
                  color_ff <= req_color;
                  fill_ff  <= '0;
                  busy_ff  <= 1'b1;
                  state_ff <= (command_type'(req_command) == CMD_FILL) ? S_FILL : S_MUL;
               end
            end
            S_MUL: begin
               state_ff <= S_ADDR;
            end
            S_ADDR: begin
               state_ff <= S_READ;
            end
            S_READ: begin
               if (cmd_ff == CMD_SET) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_color_ff   <= color_ff;
                  rsp_clamped_ff <= idx_clamped;
                  busy_ff        <= 1'b0;
                  state_ff       <= S_IDLE;
               end else begin
                  state_ff <= S_MIX;
               end
            end
            S_MIX: begin
               if (cmd_ff == CMD_GET) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_color_ff   <= rd_data_ff;
                  rsp_clamped_ff <= idx_clamped;
                  busy_ff        <= 1'b0;
                  state_ff       <= S_IDLE;
               end else begin
                  mix_ff[2] <= mix_sum(color_ff[23:16], rd_data_ff[23:16], color_ff[31:24]);
                  mix_ff[1] <= mix_sum(color_ff[15:8], rd_data_ff[15:8], color_ff[31:24]);
                  mix_ff[0] <= mix_sum(color_ff[7:0], rd_data_ff[7:0], color_ff[31:24]);
                  state_ff  <= S_WRITE;
               end
            end
            S_WRITE: begin
               rsp_valid_ff   <= 1'b1;
               rsp_color_ff   <= blend_word;
               rsp_clamped_ff <= idx_clamped;
               busy_ff        <= 1'b0;
               state_ff       <= S_IDLE;
            end
            S_FILL: begin
               if (fill_ff == fill_last) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_color_ff   <= '0;
                  rsp_clamped_ff <= 1'b0;
                  busy_ff        <= 1'b0;
                  state_ff       <= S_IDLE;
               end else begin
                  fill_ff <= fill_ff + AW'(1);
               end
            end
            default: begin
               busy_ff  <= 1'b0;
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy              = busy_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_color    = rsp_color_ff;
   assign rsp_index_clamped = rsp_clamped_ff;

   // One request in flight: responses never come in adjacent cycles
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back response strobes");

   // A transfer occupies the block and gives no response in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("request transfer did not raise busy");

   // Fill answers with zero colour and no clamp
   a_fill_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (cmd_ff == CMD_FILL)) |-> ((rsp_read_color == '0) && !rsp_index_clamped))
      else $error("fill response not zero");

   // Fill sweep stays inside the pixels in use
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |-> (fill_ff <= fill_last))
      else $error("fill address beyond pixel count");

endmodule

`default_nettype wire

// ===== bench/pixel_reply_checker.sv =====
// ----------------------------------------------------------------------------
// pixel_reply_checker: reply predictor and comparator for the pixel store
// Watches the register port, the request channel and the reply channel of the
// pixel store blend engine. Keeps its own copy of the registers and of the
// pixel memory, works out the reply of every request transfer and compares
// each reply transfer, field by field, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module pixel_reply_checker #(
   parameter int PIXELS = 65536
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   input  wire                 busy,
   input  wire logic [1:0]     req_command,
   input  wire logic signed [pse_pkg::POS_WIDTH-1:0] req_pos_x,
   input  wire logic signed [pse_pkg::POS_WIDTH-1:0] req_pos_y,
   input  wire logic [pse_pkg::COLOR_WIDTH-1:0]      req_color,
   input  wire                 rsp_valid,
   input  wire logic [pse_pkg::COLOR_WIDTH-1:0]      rsp_read_color,
   input  wire                 rsp_index_clamped,
   input  wire                 csr_we,
   input  wire logic [1:0]     csr_index,
   input  wire logic [pse_pkg::CSR_WIDTH-1:0]        csr_data,
   output int                  fail_count,
   output int                  outstanding,
   output int                  reply_count,
   output int                  clamp_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import pse_pkg::*;

   localparam int PRINT_CAP = 40;

   typedef struct {
      logic [COLOR_WIDTH-1:0] color;
      logic                   clamped;
      command_type            op;
      int                     serial;
   } reply_type;

   // Shadow of the block's state
   logic [COLOR_WIDTH-1:0] pixel_copy [PIXELS];
   longint                 x_shift;
   longint                 y_shift;
   longint                 row_pitch;
   longint                 count_setting;

   reply_type expected_replies [$];
   int        mismatches = 0;
   int        requests_seen = 0;
   int        replies_seen = 0;
   int        clamps_seen = 0;

   initial begin
      fail_count  = 0;
      outstanding = 0;
      reply_count = 0;
      clamp_count = 0;
   end

   task automatic report_mismatch(input string what, input int serial,
                                  input logic [COLOR_WIDTH-1:0] got,
                                  input logic [COLOR_WIDTH-1:0] want);
      mismatches++;
      if (mismatches <= PRINT_CAP) begin
         $display("MISMATCH at %0t, request %0d: %s got %h want %h",
                  $realtime, serial, what, got, want);
      end
   endtask

   // Pixels in use: the count register saturated into 1 .. PIXELS
   function automatic longint pixels_in_use();
      if (count_setting == 0) return 1;
      if (count_setting > PIXELS) return PIXELS;
      return count_setting;
   endfunction

   // Linear index of a position, clamped into the pixels in use
   function automatic int unsigned locate_pixel(input logic signed [POS_WIDTH-1:0] px,
                                                input logic signed [POS_WIDTH-1:0] py,
                                                output logic clamped);
      longint span;
      longint spot;
      span    = pixels_in_use();
      spot    = (longint'(px) + x_shift) + (longint'(py) + y_shift) * row_pitch;
      clamped = 1'b0;
      if (spot < 0) begin
         clamped = 1'b1;
         return 0;
      end
      if (spot >= span) begin
         clamped = 1'b1;
         return int'(span - 1);
      end
      return int'(spot);
   endfunction

   // One channel of blend-over, truncating divide
   function automatic logic [7:0] mix_channel(input logic [7:0] fg, input logic [7:0] bg,
                                              input logic [7:0] a);
      int total;
      total = int'(fg) * int'(a) + int'(bg) * (255 - int'(a));
      return 8'(total / 255);
   endfunction

   function automatic logic [COLOR_WIDTH-1:0] blend_pixel(input logic [COLOR_WIDTH-1:0] fg,
                                                          input logic [COLOR_WIDTH-1:0] bg);
      return {ALPHA_OPAQUE,
              mix_channel(fg[23:16], bg[23:16], fg[31:24]),
              mix_channel(fg[15:8],  bg[15:8],  fg[31:24]),
              mix_channel(fg[7:0],   bg[7:0],   fg[31:24])};
   endfunction

   // Update the pixel copy for one request and work out its reply
   task automatic apply_request(input command_type op,
                                input logic signed [POS_WIDTH-1:0] px,
                                input logic signed [POS_WIDTH-1:0] py,
                                input logic [COLOR_WIDTH-1:0] color,
                                output reply_type r);
      int unsigned spot;
      logic        clamped;
      longint      span;
      r.op      = op;
      r.serial  = requests_seen;
      r.color   = '0;
      r.clamped = 1'b0;
      if (op == CMD_FILL) begin
         span = pixels_in_use();
         for (longint i = 0; i < span; i++) pixel_copy[i] = color;
      end else begin
         spot      = locate_pixel(px, py, clamped);
         r.clamped = clamped;
         case (op)
            CMD_SET: begin
               pixel_copy[spot] = color;
               r.color = color;
            end
            CMD_BLEND: begin
               r.color = blend_pixel(color, pixel_copy[spot]);
               pixel_copy[spot] = r.color;
            end
            default: begin
               r.color = pixel_copy[spot];
            end
         endcase
      end
   endtask

   // Follow register writes, request transfers and reply transfers
   always @(posedge clock) begin : watch
      reply_type fresh;
      reply_type oldest;
      if (reset) begin
         x_shift       = 0;
         y_shift       = 0;
         row_pitch     = longint'(ROW_PITCH_RESET);
         count_setting = longint'(PIXEL_COUNT_RESET);
      end else begin
         if (csr_we) begin
            case (reg_index_type'(csr_index))
               REG_X_OFFSET:    x_shift       = longint'(csr_data[XOFF_WIDTH-1:0]);
               REG_Y_OFFSET:    y_shift       = longint'(csr_data[YOFF_WIDTH-1:0]);
               REG_ROW_PITCH:   row_pitch     = longint'(csr_data[PITCH_WIDTH-1:0]);
               REG_PIXEL_COUNT: count_setting = longint'(csr_data[COUNT_REG_WIDTH-1:0]);
               default: ;
            endcase
         end
         if (start && !busy) begin
            apply_request(command_type'(req_command), req_pos_x, req_pos_y, req_color, fresh);
            expected_replies.push_back(fresh);
            requests_seen++;
         end
         if (rsp_valid) begin
            replies_seen++;
            if (rsp_index_clamped) clamps_seen++;
            if (expected_replies.size() == 0) begin
               report_mismatch("reply with nothing outstanding", -1,
                               rsp_read_color, '0);
            end else begin
               oldest = expected_replies.pop_front();
               if (rsp_read_color !== oldest.color) begin
                  report_mismatch({oldest.op.name(), " read_color"}, oldest.serial,
                                  rsp_read_color, oldest.color);
               end
               if (rsp_index_clamped !== oldest.clamped) begin
                  report_mismatch({oldest.op.name(), " index_clamped"}, oldest.serial,
                                  {31'b0, rsp_index_clamped}, {31'b0, oldest.clamped});
               end
            end
         end
      end
      // Hand the tallies over after the edge
      outstanding <= expected_replies.size();
      fail_count  <= mismatches;
      reply_count <= replies_seen;
      clamp_count <= clamps_seen;
   end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the pixel store blend engine
// Clears the whole store, runs a directed set of requests at the field and
// register extremes, then random bursts of set, blend, get and fill under
// several register settings. Prediction and comparison sit in the checker.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pse_pkg::*;

   localparam int PIXELS          = 65536;
   localparam int IDLE_LIMIT      = 300000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int FILL_CEILING    = 4096;
   localparam int TAIL_CYCLES     = 16;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic [1:0]                   req_command = CMD_SET;
   logic signed [POS_WIDTH-1:0]  req_pos_x = '0;
   logic signed [POS_WIDTH-1:0]  req_pos_y = '0;
   logic [COLOR_WIDTH-1:0]       req_color = '0;
   logic                         csr_we = 1'b0;
   logic [1:0]                   csr_index = REG_X_OFFSET;
   logic [CSR_WIDTH-1:0]         csr_data = '0;
   logic                         busy;
   logic                         rsp_valid;
   logic [COLOR_WIDTH-1:0]       rsp_read_color;
   logic                         rsp_index_clamped;

   int fail_count;
   int outstanding;
   int reply_count;
   int clamp_count;

   // Register values as the block sees them, for aiming positions
   longint eff_xo = 0;
   longint eff_yo = 0;
   longint eff_pitch = 256;
   longint eff_in_use = PIXELS;

   int sent [4] = '{default: 0};

   pixel_store_blend_engine #(.PIXELS(PIXELS)) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_color         (req_color),
      .rsp_valid         (rsp_valid),
      .rsp_read_color    (rsp_read_color),
      .rsp_index_clamped (rsp_index_clamped),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   pixel_reply_checker #(.PIXELS(PIXELS)) replies (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_color         (req_color),
      .rsp_valid         (rsp_valid),
      .rsp_read_color    (rsp_read_color),
      .rsp_index_clamped (rsp_index_clamped),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .fail_count        (fail_count),
      .outstanding       (outstanding),
      .reply_count       (reply_count),
      .clamp_count       (clamp_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Present one request and hold it until it transfers
   task automatic issue(input command_type op, input logic [POS_WIDTH-1:0] px,
                        input logic [POS_WIDTH-1:0] py, input logic [COLOR_WIDTH-1:0] color);
      req_command <= op;
      req_pos_x   <= px;
      req_pos_y   <= py;
      req_color   <= color;
      start       <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent[op]++;
   endtask

   // Drop start and wait until every reply is in and the block is idle
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 || busy) @(posedge clock);
   endtask

   // Write all four registers back to back while idle
   task automatic program_regs(input logic [CSR_WIDTH-1:0] xo, input logic [CSR_WIDTH-1:0] yo,
                               input logic [CSR_WIDTH-1:0] pitch,
                               input logic [CSR_WIDTH-1:0] count);
      settle();
      csr_we    <= 1'b1;
      csr_index <= REG_X_OFFSET;
      csr_data  <= xo;
      @(posedge clock);
      csr_index <= REG_Y_OFFSET;
      csr_data  <= yo;
      @(posedge clock);
      csr_index <= REG_ROW_PITCH;
      csr_data  <= pitch;
      @(posedge clock);
      csr_index <= REG_PIXEL_COUNT;
      csr_data  <= count;
      @(posedge clock);
      csr_we    <= 1'b0;
      eff_xo    = longint'(xo[XOFF_WIDTH-1:0]);
      eff_yo    = longint'(yo[YOFF_WIDTH-1:0]);
      eff_pitch = longint'(pitch[PITCH_WIDTH-1:0]);
      eff_in_use = longint'(count);
      if (eff_in_use == 0) eff_in_use = 1;
      if (eff_in_use > PIXELS) eff_in_use = PIXELS;
   endtask

   // Mostly aim at a pixel in use, sometimes just outside, sometimes anywhere
   task automatic pick_position(output logic [POS_WIDTH-1:0] px,
                                output logic [POS_WIDTH-1:0] py);
      int     sel;
      longint target;
      longint x;
      longint y;
      sel = $urandom_range(0, 99);
      px  = POS_WIDTH'($urandom);
      py  = POS_WIDTH'($urandom);
      if (sel >= 20) begin
         if (sel < 25) target = -longint'($urandom_range(1, 40));
         else if (sel < 30) target = eff_in_use + longint'($urandom_range(0, 40));
         else target = longint'($urandom_range(0, int'(eff_in_use - 1)));
         if (eff_pitch == 0) y = longint'($urandom_range(0, 64)) - 32;
         else y = target / eff_pitch - eff_yo + longint'($urandom_range(0, 2)) - 1;
         x = target - eff_xo - (y + eff_yo) * eff_pitch;
         if (x >= -32768 && x <= 32767 && y >= -32768 && y <= 32767) begin
            px = x[POS_WIDTH-1:0];
            py = y[POS_WIDTH-1:0];
         end
      end
   endtask

   // Random bursts with random gaps between them
   task automatic random_phase(input int count);
      int                     done;
      int                     burst;
      int                     sel;
      command_type            op;
      logic [POS_WIDTH-1:0]   px;
      logic [POS_WIDTH-1:0]   py;
      logic [COLOR_WIDTH-1:0] color;
      done = 0;
      while (done < count) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && done < count; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) op = CMD_SET;
            else if (sel < 60) op = CMD_BLEND;
            else if (sel < 96) op = CMD_GET;
            else if (eff_in_use <= FILL_CEILING) op = CMD_FILL;
            else op = CMD_GET;
            pick_position(px, py);
            color = $urandom;
            sel = $urandom_range(0, 7);
            if (sel == 0) color[31:24] = 8'h00;
            else if (sel == 1) color[31:24] = ALPHA_OPAQUE;
            issue(op, px, py, color);
            done++;
         end
         if (done < count && $urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   endtask

   // Watchdog: end the run when nothing transfers for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Clear the whole store under the reset settings, then the edges
      issue(CMD_FILL,  16'h0000, 16'h0000, 32'h0000_0000);
      issue(CMD_GET,   16'h0000, 16'h0000, 32'hFFFF_FFFF);
      issue(CMD_SET,   16'd255,  16'd255,  32'hFFFF_FFFF);
      issue(CMD_SET,   16'h0000, 16'd256,  32'h1357_9BDF);
      issue(CMD_GET,   16'd255,  16'd255,  32'h0000_0000);
      issue(CMD_SET,   16'hFFFF, 16'h0000, 32'h00C0_FFEE);
      issue(CMD_GET,   16'h0000, 16'h0000, 32'h0000_0000);
      issue(CMD_SET,   16'h7FFF, 16'h7FFF, 32'h8000_0001);
      issue(CMD_SET,   16'h8000, 16'h8000, 32'h7FFF_FFFE);
      issue(CMD_SET,   16'd10,   16'd1,    32'h0012_3456);
      issue(CMD_BLEND, 16'd10,   16'd1,    32'h00FE_DCBA);
      issue(CMD_BLEND, 16'd10,   16'd1,    32'hFF0F_1E2D);
      issue(CMD_BLEND, 16'd10,   16'd1,    32'h80F0_A050);
      issue(CMD_GET,   16'd10,   16'd1,    32'h0000_0000);

      // Zero pitch and a zero count: everything lands on pixel zero
      program_regs(17'd5, 17'd7, 17'd0, 17'd0);
      issue(CMD_SET,   16'd100,  16'd5,    32'h0BAD_F00D);
      issue(CMD_GET,   16'hFFFB, 16'd123,  32'h0000_0000);
      issue(CMD_FILL,  16'h0000, 16'h0000, 32'hA5A5_A5A5);
      issue(CMD_GET,   16'h0000, 16'h0000, 32'h0000_0000);

      // Count above the store saturates; refill everything
      program_regs(17'd0, 17'd0, 17'd0, 17'h1FFFF);
      issue(CMD_SET,   16'h7FFF, 16'h0000, 32'h2468_1357);
      issue(CMD_GET,   16'h7FFF, 16'd1234, 32'h0000_0000);
      issue(CMD_FILL,  16'h0000, 16'h0000, 32'h5A5A_C3C3);
      issue(CMD_GET,   16'd100,  16'h0000, 32'h0000_0000);

      // Largest offsets with a pitch of 4096
      program_regs(17'd4095, 17'd4095, 17'd4096, 17'd65536);
      issue(CMD_SET,   16'h0000, 16'h0000, 32'hC001_D00D);
      issue(CMD_BLEND, 16'hFFFF, 16'hFFFF, 32'h4080_40C0);
      issue(CMD_GET,   16'h8000, 16'h8000, 32'h0000_0000);

      // Random phases over a spread of register settings
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: program_regs(17'd0, 17'd0, 17'd256, 17'd65536);
            1: program_regs(17'd4095, 17'd4095, 17'd4096, 17'd65536);
            2: program_regs(CSR_WIDTH'($urandom_range(0, 63)),
                            CSR_WIDTH'($urandom_range(0, 63)),
                            CSR_WIDTH'($urandom_range(1, 300)),
                            CSR_WIDTH'($urandom_range(1, FILL_CEILING)));
            3: program_regs(17'd0, 17'd0, 17'd0, 17'd200);
            4: program_regs(CSR_WIDTH'($urandom_range(0, 4095)),
                            CSR_WIDTH'($urandom_range(0, 4095)),
                            17'd8191, 17'h1FFFF);
            5: program_regs(17'd0, 17'd0, 17'd1, 17'd0);
            6: program_regs(CSR_WIDTH'($urandom), CSR_WIDTH'($urandom),
                            CSR_WIDTH'($urandom), CSR_WIDTH'($urandom));
            default: program_regs(17'd17, 17'd3, 17'd64, 17'd1024);
         endcase
         random_phase(ITEMS_PER_PHASE);
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d sets, %0d blends, %0d gets and %0d fills over %0d settings",
               sent[CMD_SET], sent[CMD_BLEND], sent[CMD_GET], sent[CMD_FILL], PHASES + 4);
      $display("%0d replies compared, %0d of them flagged as clamped, %0d mismatches",
               reply_count, clamp_count, fail_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
